// ----- sv/etl_pkg.sv -----
package etl_pkg;

    // Fixed-point formats
    localparam int FRAC_BITS = 16;
    localparam int QW        = 31;    // Q30 value up to and including 1.0

    localparam logic [30:0] ONE       = 31'h4000_0000;
    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [29:0] LN2_Q30   = 30'd744261118;

    // exp(-u) Horner series order and reciprocal divider slicing
    localparam int HORNER_N   = 7;
    localparam int DIV_BITS   = 4;
    localparam int DIV_STAGES = (QW + DIV_BITS - 1) / DIV_BITS;

    // Register indexes on the configuration channel
    localparam logic [7:0] REG_LOSS_SCALE   = 8'd0;
    localparam logic [7:0] REG_GRAD_CLIP    = 8'd1;
    localparam logic [7:0] REG_HESS_FLOOR   = 8'd2;
    localparam logic [7:0] REG_HESS_CEILING = 8'd3;

    localparam logic [22:0] LOSS_SCALE_RST   = 23'd1310720;
    localparam logic [21:0] GRAD_CLIP_RST    = 22'd3276800;
    localparam logic [25:0] HESS_FLOOR_RST   = 26'd6554;
    localparam logic [25:0] HESS_CEILING_RST = 26'd65536000;

    typedef struct packed {
        logic signed [23:0] score;
        logic [31:0]        row_time;
        logic [31:0]        col_time;
        logic               last_in;
    } sample_t;

    typedef struct packed {
        logic signed [22:0] grad_value;
        logic [25:0]        hess_value;
        logic               last_out;
    } result_t;

    typedef struct packed {
        logic [7:0]  index;
        logic [31:0] value;
    } cfg_t;

    typedef struct packed {
        logic [22:0] loss_scale;
        logic [21:0] grad_clip;
        logic [25:0] hess_floor;
        logic [25:0] hess_ceiling;
    } cfg_regs_t;

    // Per-sample values that ride alongside the sigmoid
    typedef struct packed {
        logic [31:0] ad;
        logic        col_quick;
        logic        last;
    } side_t;

    // floor(t / n) for a small constant n, given recip = floor(2^32 / n)
    function automatic logic [29:0] div_small(input logic [29:0] t,
                                              input logic [32:0] recip,
                                              input logic [2:0]  n);
        logic [62:0] pr;
        logic [29:0] qe;
        logic [32:0] qn;
        logic [30:0] rem;
        pr  = t * recip;
        qe  = pr[61:32];
        qn  = qe * n;
        rem = {1'b0, t} - {1'b0, qn[29:0]};
        if (rem >= {28'd0, n})
        begin
            qe = qe + 30'd1;
        end
        return qe;
    endfunction

endpackage

// ----- sv/etl_if.sv -----
interface etl_sample_if;
    logic             valid;
    logic             ready;
    etl_pkg::sample_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface etl_result_if;
    logic             valid;
    logic             ready;
    etl_pkg::result_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface etl_cfg_if;
    logic          valid;
    logic          ready;
    etl_pkg::cfg_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/expected_time_loss_grad_hess.sv -----
// Expected-time loss gradient and Hessian, one sample per transaction.
//
// Channels: sample (sink) takes score, row_time, col_time, last_in;
// result (source) gives grad_value, hess_value, last_out, one result per
// sample and in order; cfg (sink) writes loss_scale, grad_clip, hess_floor
// and hess_ceiling by index 0 to 3, other indexes are dropped. cfg is always
// ready; write it only while no sample is in flight.
// Throughput: one sample per cycle while the pipeline is not frozen. A sample
// passes through 38 register stages on its way to result: the input
// stage (loaded at the accepting edge), 26 stages of sigmoid (exponent
// split, seven Horner steps of two stages each, a 2^-k shift, an
// eight-stage restoring divider at up to four quotient bits per stage and the
// sign mirror), ten stages of loss arithmetic with the wide products cut into
// halves, and the output register.
// Reset: all valid bits clear, configuration returns to 20.0, 50.0, 0.1 and
// 1000.0.
// Stall: when result is held off, one result parks in a skid register and
// the whole pipeline then freezes; sample.ready is a register output and
// nothing in flight is dropped or repeated.
module expected_time_loss_grad_hess (
    input  logic          clk,
    input  logic          rst_n,
    etl_sample_if.sink    sample,
    etl_result_if.source  result,
    etl_cfg_if.sink       cfg
);

    // Configuration registers
    etl_pkg::cfg_regs_t cfg_regs_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_regs_reg.loss_scale   <= etl_pkg::LOSS_SCALE_RST;
            cfg_regs_reg.grad_clip    <= etl_pkg::GRAD_CLIP_RST;
            cfg_regs_reg.hess_floor   <= etl_pkg::HESS_FLOOR_RST;
            cfg_regs_reg.hess_ceiling <= etl_pkg::HESS_CEILING_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.data.index)
                etl_pkg::REG_LOSS_SCALE:   cfg_regs_reg.loss_scale   <= cfg.data.value[22:0];
                etl_pkg::REG_GRAD_CLIP:    cfg_regs_reg.grad_clip    <= cfg.data.value[21:0];
                etl_pkg::REG_HESS_FLOOR:   cfg_regs_reg.hess_floor   <= cfg.data.value[25:0];
                etl_pkg::REG_HESS_CEILING: cfg_regs_reg.hess_ceiling <= cfg.data.value[25:0];
                default: ;
            endcase
        end
    end

    // Pipeline advance: freeze every stage before the output register while the skid register is full
    logic skid_v_reg;
    logic en;

    assign en           = !skid_v_reg;
    assign sample.ready = en;

    // Input stage: score magnitude and sign, runtime gap and which is faster
    logic           neg_next;
    logic [23:0]    mag_next;
    logic           cf_next;
    etl_pkg::side_t side_next;

    logic           v0_reg;
    logic [23:0]    mag0_reg;
    logic           neg0_reg;
    etl_pkg::side_t side0_reg;

    always_comb
    begin
        neg_next = sample.data.score[23];
        mag_next = neg_next ? (~$unsigned(sample.data.score) + 24'd1)
                            : $unsigned(sample.data.score);
        cf_next  = sample.data.col_time < sample.data.row_time;
        side_next.col_quick = cf_next;
        side_next.ad   = cf_next ? sample.data.row_time - sample.data.col_time
                                 : sample.data.col_time - sample.data.row_time;
        side_next.last = sample.data.last_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag0_reg  <= mag_next;
            neg0_reg  <= neg_next;
            side0_reg <= side_next;
        end
    end

    // Sigmoid, with the sample's side values carried alongside
    logic           sig_v;
    logic [30:0]    sig_p;
    etl_pkg::side_t sig_side;

    etl_sigmoid u_sigmoid (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v0_reg),
        .score_mag (mag0_reg),
        .score_neg (neg0_reg),
        .side_in   (side0_reg),
        .out_valid (sig_v),
        .prob      (sig_p),
        .side_out  (sig_side)
    );

    // Gradient and Hessian
    logic             loss_v;
    etl_pkg::result_t loss_res;

    etl_loss u_loss (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sig_v),
        .prob      (sig_p),
        .side_in   (sig_side),
        .cfg_regs  (cfg_regs_reg),
        .out_valid (loss_v),
        .result    (loss_res)
    );

    // Output register with skid: load when empty or taken, else park
    logic             res_v_reg;
    etl_pkg::result_t res_d_reg;
    etl_pkg::result_t skid_d_reg;
    logic             out_free;

    assign out_free = !res_v_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_v_reg)
            begin
                res_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end
            else
            begin
                res_v_reg <= en && loss_v;
            end
        end
        else if (en && loss_v)
        begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            res_d_reg <= skid_v_reg ? skid_d_reg : loss_res;
        end
        else if (en && loss_v)
        begin
            skid_d_reg <= loss_res;
        end
    end

    assign result.valid = res_v_reg;
    assign result.data  = res_d_reg;

    // A parked result always has one in front of it
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> res_v_reg)
        else $error("skid register full while output register empty");

    // Once the front result goes, the parked one follows at once
    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg && result.ready |=> res_v_reg && !skid_v_reg)
        else $error("parked result not promoted");

    a_grad_pos_clip: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.data.grad_value[22]
        |-> $unsigned(result.data.grad_value) <= {1'b0, cfg_regs_reg.grad_clip})
        else $error("positive gradient above clip");

    a_grad_neg_clip: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.data.grad_value[22]
        |-> (23'd0 - $unsigned(result.data.grad_value)) <= {1'b0, cfg_regs_reg.grad_clip})
        else $error("negative gradient below clip");

    a_hess_window: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (cfg_regs_reg.hess_floor <= cfg_regs_reg.hess_ceiling)
        |-> result.data.hess_value >= cfg_regs_reg.hess_floor
            && result.data.hess_value <= cfg_regs_reg.hess_ceiling)
        else $error("hessian outside floor and ceiling");

endmodule

// ----- sv/etl_sigmoid.sv -----
module etl_sigmoid (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [23:0]         score_mag,
    input  logic                score_neg,
    input  etl_pkg::side_t      side_in,
    output logic                out_valid,
    output logic [30:0]         prob,
    output etl_pkg::side_t      side_out
);

    localparam int HN = etl_pkg::HORNER_N;
    localparam int DS = etl_pkg::DIV_STAGES;
    localparam int DB = etl_pkg::DIV_BITS;

    // exponent split: y = |s| * log2(e)
    logic [54:0]    y_prod;
    logic           v1_reg;
    logic [8:0]     k1_reg;
    logic [29:0]    f1_reg;
    logic           neg1_reg;
    etl_pkg::side_t side1_reg;

    // fraction back to natural base
    logic [59:0]    u_prod;
    logic           v2_reg;
    logic [8:0]     k2_reg;
    logic [29:0]    u2_reg;
    logic           neg2_reg;
    etl_pkg::side_t side2_reg;

    assign y_prod = score_mag * etl_pkg::LOG2E_Q30;
    assign u_prod = f1_reg * etl_pkg::LN2_Q30;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k1_reg    <= y_prod[54:46];
            f1_reg    <= y_prod[45:16];
            neg1_reg  <= score_neg;
            side1_reg <= side_in;
            k2_reg    <= k1_reg;
            u2_reg    <= u_prod[59:30];
            neg2_reg  <= neg1_reg;
            side2_reg <= side1_reg;
        end
    end

    // Horner steps of exp(-u): multiply half, then constant divide half
    logic           mv_reg    [HN];
    logic [29:0]    mt_reg    [HN];
    logic [29:0]    mu_reg    [HN];
    logic [8:0]     mk_reg    [HN];
    logic           mneg_reg  [HN];
    etl_pkg::side_t mside_reg [HN];
    logic           dv_reg    [HN];
    logic [30:0]    dr_reg    [HN];
    logic [29:0]    du_reg    [HN];
    logic [8:0]     dk_reg    [HN];
    logic           dneg_reg  [HN];
    etl_pkg::side_t dside_reg [HN];

    for (genvar j = 0; j < HN; j++)
    begin : g_horner
        localparam int          N     = HN - j;
        localparam logic [32:0] RECIP = 33'((64'd1 << 32) / N);

        logic           v_in;
        logic [30:0]    r_in;
        logic [29:0]    u_in;
        logic [8:0]     k_in;
        logic           neg_in;
        etl_pkg::side_t side_w;
        logic [60:0]    t_prod;
        logic [29:0]    q_div;

        if (j == 0)
        begin : g_first
            assign v_in   = v2_reg;
            assign r_in   = etl_pkg::ONE;
            assign u_in   = u2_reg;
            assign k_in   = k2_reg;
            assign neg_in = neg2_reg;
            assign side_w = side2_reg;
        end
        else
        begin : g_next
            assign v_in   = dv_reg[j-1];
            assign r_in   = dr_reg[j-1];
            assign u_in   = du_reg[j-1];
            assign k_in   = dk_reg[j-1];
            assign neg_in = dneg_reg[j-1];
            assign side_w = dside_reg[j-1];
        end

        assign t_prod = u_in * r_in;
        assign q_div  = etl_pkg::div_small(mt_reg[j], RECIP, 3'(N));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                mv_reg[j] <= 1'b0;
                dv_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                mv_reg[j] <= v_in;
                dv_reg[j] <= mv_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                mt_reg[j]    <= t_prod[59:30];
                mu_reg[j]    <= u_in;
                mk_reg[j]    <= k_in;
                mneg_reg[j]  <= neg_in;
                mside_reg[j] <= side_w;
                dr_reg[j]    <= etl_pkg::ONE - {1'b0, q_div};
                du_reg[j]    <= mu_reg[j];
                dk_reg[j]    <= mk_reg[j];
                dneg_reg[j]  <= mneg_reg[j];
                dside_reg[j] <= mside_reg[j];
            end
        end
    end

    // scale by 2^-k and form the divisor 1 + e
    logic [30:0]    e_val;
    logic           ev_reg;
    logic [31:0]    den_reg;
    logic           eneg_reg;
    etl_pkg::side_t eside_reg;

    assign e_val = dr_reg[HN-1] >> dk_reg[HN-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_reg <= 1'b0;
        end
        else if (en)
        begin
            ev_reg <= dv_reg[HN-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg   <= {1'b0, etl_pkg::ONE} + {1'b0, e_val};
            eneg_reg  <= dneg_reg[HN-1];
            eside_reg <= dside_reg[HN-1];
        end
    end

    // restoring divider for 2^60 / den, up to DIV_BITS quotient bits per stage
    logic           qv_reg    [DS];
    logic [30:0]    qrem_reg  [DS];
    logic [30:0]    qq_reg    [DS];
    logic [31:0]    qden_reg  [DS];
    logic           qneg_reg  [DS];
    etl_pkg::side_t qside_reg [DS];

    for (genvar i = 0; i < DS; i++)
    begin : g_div
        logic           v_in;
        logic [30:0]    rem_in;
        logic [30:0]    q_in;
        logic [31:0]    den_in;
        logic           neg_in;
        etl_pkg::side_t side_w;
        logic [30:0]    rem_next;
        logic [30:0]    q_next;

        if (i == 0)
        begin : g_first
            assign v_in   = ev_reg;
            assign rem_in = 31'h2000_0000;
            assign q_in   = '0;
            assign den_in = den_reg;
            assign neg_in = eneg_reg;
            assign side_w = eside_reg;
        end
        else
        begin : g_next
            assign v_in   = qv_reg[i-1];
            assign rem_in = qrem_reg[i-1];
            assign q_in   = qq_reg[i-1];
            assign den_in = qden_reg[i-1];
            assign neg_in = qneg_reg[i-1];
            assign side_w = qside_reg[i-1];
        end

        always_comb
        begin : p_steps
            logic [31:0] sh;
            rem_next = rem_in;
            q_next   = q_in;
            for (int s = 0; s < DB; s++)
            begin
                if (i * DB + s < etl_pkg::QW)
                begin
                    sh = {rem_next, 1'b0};
                    if (sh >= den_in)
                    begin
                        rem_next = 31'(sh - den_in);
                        q_next   = {q_next[29:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = sh[30:0];
                        q_next   = {q_next[29:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                qv_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                qv_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                qrem_reg[i]  <= rem_next;
                qq_reg[i]    <= q_next;
                qden_reg[i]  <= den_in;
                qneg_reg[i]  <= neg_in;
                qside_reg[i] <= side_w;
            end
        end
    end

    // mirror for negative scores
    logic           pv_reg;
    logic [30:0]    p_reg;
    etl_pkg::side_t pside_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
        end
        else if (en)
        begin
            pv_reg <= qv_reg[DS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg     <= qneg_reg[DS-1] ? etl_pkg::ONE - qq_reg[DS-1] : qq_reg[DS-1];
            pside_reg <= qside_reg[DS-1];
        end
    end

    assign out_valid = pv_reg;
    assign prob      = p_reg;
    assign side_out  = pside_reg;

endmodule

// ----- sv/etl_loss.sv -----
module etl_loss (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [30:0]          prob,
    input  etl_pkg::side_t       side_in,
    input  etl_pkg::cfg_regs_t   cfg_regs,
    output logic                 out_valid,
    output etl_pkg::result_t     result
);

    logic [9:0] v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[8:0], in_valid};
        end
    end

    // stage 1: sp, diff, ad^2, |2P-1|
    logic [30:0] sel_next;
    logic [31:0] two_p;
    logic        gtr_next;
    logic [62:0] diff_prod;
    logic [61:0] sp_prod;
    logic [63:0] aa_prod;
    logic [30:0] m_next;

    assign sel_next  = side_in.col_quick ? etl_pkg::ONE - prob : prob;
    assign two_p     = {prob, 1'b0};
    assign gtr_next  = two_p > {1'b0, etl_pkg::ONE};
    assign m_next    = gtr_next ? 31'(two_p - {1'b0, etl_pkg::ONE})
                                : 31'({1'b0, etl_pkg::ONE} - two_p);
    assign diff_prod = side_in.ad * sel_next;
    assign sp_prod   = prob * (etl_pkg::ONE - prob);
    assign aa_prod   = side_in.ad * side_in.ad;

    logic [31:0] diff1_reg, ad1_reg;
    logic [29:0] sp1_reg;
    logic [47:0] aa1_reg;
    logic [30:0] m1_reg;
    logic        bneg1_reg, cf1_reg, last1_reg;

    // stage 2: diff * ad
    logic [63:0] dd_prod;
    logic [47:0] dd2_reg, aa2_reg;
    logic [29:0] sp2_reg;
    logic [30:0] m2_reg;
    logic        bneg2_reg, cf2_reg, last2_reg;

    assign dd_prod = diff1_reg * ad1_reg;

    // stage 3: partial products of dd*sp and aa*sp
    logic [53:0] pxl_reg, pxh_reg, pyl_reg, pyh_reg;
    logic [29:0] sp3_reg;
    logic [30:0] m3_reg;
    logic        bneg3_reg, cf3_reg, last3_reg;

    // stage 4: assemble X = dd*sp>>30, Y = aa*sp>>30
    logic [77:0] x_sum, y_sum;
    logic [45:0] x4_reg, y4_reg;
    logic [29:0] sp4_reg;
    logic [30:0] m4_reg;
    logic        bneg4_reg, cf4_reg, last4_reg;

    assign x_sum = {pxh_reg, 24'd0} + 78'(pxl_reg);
    assign y_sum = {pyh_reg, 24'd0} + 78'(pyl_reg);

    // stage 5: partials of B, A and scaled gradient
    logic [53:0] pbl_reg, pbh_reg;
    logic [52:0] pal_reg, pah_reg;
    logic [45:0] pgl_reg, pgh_reg;
    logic        bneg5_reg, cf5_reg, last5_reg;

    // stage 6: assemble
    logic [76:0] b_sum;
    logic [75:0] a_sum;
    logic [68:0] g_sum;
    logic [45:0] b6_reg;
    logic [43:0] a6_reg;
    logic [53:0] gm6_reg;
    logic        bneg6_reg, cf6_reg, last6_reg;

    assign b_sum = {pbh_reg, 23'd0} + 77'(pbl_reg);
    assign a_sum = {pah_reg, 23'd0} + 76'(pal_reg);
    assign g_sum = {pgh_reg, 23'd0} + 69'(pgl_reg);

    // stage 7: combine A and B, clip gradient magnitude
    logic [46:0] hm_next;
    logic [21:0] gc_next;
    logic [46:0] hm7_reg;
    logic [21:0] gc7_reg;
    logic        cf7_reg, last7_reg;

    always_comb
    begin
        if (!bneg6_reg)
        begin
            hm_next = 47'(a6_reg) + 47'(b6_reg);
        end
        else if (47'(a6_reg) >= 47'(b6_reg))
        begin
            hm_next = 47'(a6_reg) - 47'(b6_reg);
        end
        else
        begin
            hm_next = 47'(b6_reg) - 47'(a6_reg);
        end
        gc_next = (gm6_reg > {32'd0, cfg_regs.grad_clip}) ? cfg_regs.grad_clip
                                                          : gm6_reg[21:0];
    end

    // stage 8: partials of Hessian scaling, sign the gradient
    logic [46:0] phl_reg;
    logic [45:0] phh_reg;
    logic [22:0] gs8_reg;
    logic        last8_reg;

    // stage 9: assemble scaled Hessian
    logic [69:0] h_sum;
    logic [54:0] hsc9_reg;
    logic [22:0] gs9_reg;
    logic        last9_reg;

    assign h_sum = {phh_reg, 24'd0} + 70'(phl_reg);

    // stage 10: clamp
    logic [25:0] h_ceil;
    logic [25:0] h_clamp;
    etl_pkg::result_t res_reg;

    assign h_ceil  = (hsc9_reg > {29'd0, cfg_regs.hess_ceiling}) ? cfg_regs.hess_ceiling
                                                                 : hsc9_reg[25:0];
    assign h_clamp = (h_ceil < cfg_regs.hess_floor) ? cfg_regs.hess_floor : h_ceil;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff1_reg <= diff_prod[61:30];
            ad1_reg   <= side_in.ad;
            sp1_reg   <= sp_prod[59:30];
            aa1_reg   <= aa_prod[63:16];
            m1_reg    <= m_next;
            bneg1_reg <= side_in.col_quick != gtr_next;
            cf1_reg   <= side_in.col_quick;
            last1_reg <= side_in.last;

            dd2_reg   <= dd_prod[63:16];
            aa2_reg   <= aa1_reg;
            sp2_reg   <= sp1_reg;
            m2_reg    <= m1_reg;
            bneg2_reg <= bneg1_reg;
            cf2_reg   <= cf1_reg;
            last2_reg <= last1_reg;

            pxl_reg   <= dd2_reg[23:0] * sp2_reg;
            pxh_reg   <= dd2_reg[47:24] * sp2_reg;
            pyl_reg   <= aa2_reg[23:0] * sp2_reg;
            pyh_reg   <= aa2_reg[47:24] * sp2_reg;
            sp3_reg   <= sp2_reg;
            m3_reg    <= m2_reg;
            bneg3_reg <= bneg2_reg;
            cf3_reg   <= cf2_reg;
            last3_reg <= last2_reg;

            x4_reg    <= x_sum[75:30];
            y4_reg    <= y_sum[75:30];
            sp4_reg   <= sp3_reg;
            m4_reg    <= m3_reg;
            bneg4_reg <= bneg3_reg;
            cf4_reg   <= cf3_reg;
            last4_reg <= last3_reg;

            pbl_reg   <= x4_reg[22:0] * m4_reg;
            pbh_reg   <= x4_reg[45:23] * m4_reg;
            pal_reg   <= y4_reg[22:0] * sp4_reg;
            pah_reg   <= y4_reg[45:23] * sp4_reg;
            pgl_reg   <= x4_reg[22:0] * cfg_regs.loss_scale;
            pgh_reg   <= x4_reg[45:23] * cfg_regs.loss_scale;
            bneg5_reg <= bneg4_reg;
            cf5_reg   <= cf4_reg;
            last5_reg <= last4_reg;

            b6_reg    <= b_sum[75:30];
            a6_reg    <= a_sum[73:30];
            gm6_reg   <= g_sum[68:15];
            bneg6_reg <= bneg5_reg;
            cf6_reg   <= cf5_reg;
            last6_reg <= last5_reg;

            hm7_reg   <= hm_next;
            gc7_reg   <= gc_next;
            cf7_reg   <= cf6_reg;
            last7_reg <= last6_reg;

            phl_reg   <= hm7_reg[23:0] * cfg_regs.loss_scale;
            phh_reg   <= hm7_reg[46:24] * cfg_regs.loss_scale;
            gs8_reg   <= cf7_reg ? (23'd0 - {1'b0, gc7_reg}) : {1'b0, gc7_reg};
            last8_reg <= last7_reg;

            hsc9_reg  <= h_sum[69:15];
            gs9_reg   <= gs8_reg;
            last9_reg <= last8_reg;

            res_reg.grad_value <= $signed(gs9_reg);
            res_reg.hess_value <= h_clamp;
            res_reg.last_out   <= last9_reg;
        end
    end

    assign out_valid = v_reg[9];
    assign result    = res_reg;

endmodule
